FILE: sv/slc_pkg.sv
// shared types, constants and helpers of the set-associative lru cache lookup
// no dependencies; compiled first

package slc_pkg;

    // build-time geometry
    localparam int WAYS       = 4;
    localparam int SETS       = 64;
    localparam int ADDR_WIDTH = 32;

    localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    // smallest block is 8 bytes, so at least 3 offset bits leave the tag
    localparam int TAG_W  = ADDR_WIDTH - 3;

    // field widths of the request and response
    localparam int CFG_W     = 3;
    localparam int OUT_WAY_W = 2;
    localparam int OUT_SET_W = 6;
    localparam int OUT_OFF_W = 6;
    localparam int CNT_W     = 32;

    // register port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // field width limits
    localparam logic [CFG_W-1:0] OFFSET_MIN = 3'd3;
    localparam logic [CFG_W-1:0] OFFSET_MAX = 3'd6;
    localparam logic [CFG_W-1:0] SETBITS_MAX = 3'd6;

    typedef enum logic [1:0] {
        REG_OFFSET_BITS = 2'd0,
        REG_SET_BITS    = 2'd1,
        REG_WAYS_IN_USE = 2'd2,
        REG_UNUSED      = 2'd3
    } reg_idx_t;

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    typedef struct packed {
        logic [CFG_W-1:0] offset_bits;
        logic [CFG_W-1:0] set_bits;
        logic [CFG_W-1:0] ways_in_use;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;    // latch request, start row read
        logic commit;  // update row, counters and response
    } cmd_t;

    typedef logic [WAYS-1:0][WAY_W-1:0] order_t;
    typedef logic [WAYS-1:0][TAG_W-1:0] tag_row_t;

    // one row of the set memory: tags of all ways plus recency order
    typedef struct packed {
        tag_row_t tags;
        order_t   order;
    } row_t;

    // recency order after reset: way i at position i
    function automatic order_t reset_order();
        order_t o;
        for (int i = 0; i < WAYS; i++)
        begin
            o[i] = WAY_W'(i);
        end
        return o;
    endfunction

endpackage

FILE: sv/slc_if.sv
// request and response channels of the cache lookup
// depends on slc_pkg for field widths

interface slc_req_if;
    logic                            valid;
    logic                            ready;
    logic [slc_pkg::ADDR_WIDTH-1:0]  addr;

    modport source (output valid, output addr, input ready);
    modport sink   (input valid, input addr, output ready);
endinterface

interface slc_rsp_if;
    logic                            valid;
    logic                            ready;
    logic                            hit;
    logic [slc_pkg::OUT_WAY_W-1:0]   way;
    logic [slc_pkg::OUT_SET_W-1:0]   set_index;
    logic [slc_pkg::OUT_OFF_W-1:0]   block_offset;
    logic                            evicted_valid;
    logic [slc_pkg::CNT_W-1:0]       read_total;
    logic [slc_pkg::CNT_W-1:0]       miss_total;

    modport source (output valid, output hit, output way, output set_index,
                    output block_offset, output evicted_valid, output read_total,
                    output miss_total, input ready);
    modport sink   (input valid, input hit, input way, input set_index,
                    input block_offset, input evicted_valid, input read_total,
                    input miss_total, output ready);
endinterface

FILE: sv/set_assoc_lru_cache_lookup.sv
// an accepted request first reads its set's row, then updates the row and the response
// no new request is taken until the last one has updated its set, due to the read-then-write of a set's
// tag and recency row in the single-port set memory; a stalled response holds the update
// reset: rst_n clears the controller, counters and all valid bits at once; no
// clearing pass, requests are taken from the first cycle after reset

module set_assoc_lru_cache_lookup (
    input  logic                         clk,
    input  logic                         rst_n,
    slc_req_if.sink                      req,
    slc_rsp_if.source                    rsp,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slc_pkg::PADDR_W-1:0]  paddr,
    input  logic [slc_pkg::PDATA_W-1:0]  pwdata,
    output logic [slc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    slc_pkg::cfg_t cfg;
    slc_pkg::cmd_t cmd;

    // configuration registers
    slc_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // controller
    slc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (cmd)
    );

    // datapath
    slc_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cfg           (cfg),
        .addr          (req.addr),
        .hit           (rsp.hit),
        .way           (rsp.way),
        .set_index     (rsp.set_index),
        .block_offset  (rsp.block_offset),
        .evicted_valid (rsp.evicted_valid),
        .read_total    (rsp.read_total),
        .miss_total    (rsp.miss_total)
    );

`ifndef SYNTHESIS
    // every update counts exactly one access
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> rsp.read_total == $past(rsp.read_total) + 32'd1)
        else $error("access count did not advance by one on update");

    // miss count moves exactly on misses
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (rsp.miss_total == $past(rsp.miss_total)) == rsp.hit)
        else $error("miss count out of step with hit flag");

    // a hit never reports an eviction
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.hit |-> !rsp.evicted_valid)
        else $error("eviction reported on a hit");

    // no update while a request is being taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !cmd.commit)
        else $error("request taken during an update");
`endif

endmodule

FILE: sv/slc_cfg.sv
// apb-style configuration registers: offset width, set width, ways in use
// depends on slc_pkg

module slc_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [slc_pkg::PADDR_W-1:0]  paddr,
    input  logic [slc_pkg::PDATA_W-1:0]  pwdata,
    output logic [slc_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output slc_pkg::cfg_t                cfg
);

    slc_pkg::cfg_t     cfg_reg;
    slc_pkg::reg_idx_t idx;
    logic              wr_en;

    assign pready = 1'b1;
    assign idx    = slc_pkg::reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.offset_bits <= 3'd3;
            cfg_reg.set_bits    <= 3'd6;
            cfg_reg.ways_in_use <= 3'd4;
        end
        else if (wr_en)
        begin
            case (idx)
                slc_pkg::REG_OFFSET_BITS: cfg_reg.offset_bits <= pwdata[slc_pkg::CFG_W-1:0];
                slc_pkg::REG_SET_BITS:    cfg_reg.set_bits    <= pwdata[slc_pkg::CFG_W-1:0];
                slc_pkg::REG_WAYS_IN_USE: cfg_reg.ways_in_use <= pwdata[slc_pkg::CFG_W-1:0];
                default:                  ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        case (idx)
            slc_pkg::REG_OFFSET_BITS: prdata = slc_pkg::PDATA_W'(cfg_reg.offset_bits);
            slc_pkg::REG_SET_BITS:    prdata = slc_pkg::PDATA_W'(cfg_reg.set_bits);
            slc_pkg::REG_WAYS_IN_USE: prdata = slc_pkg::PDATA_W'(cfg_reg.ways_in_use);
            default:                  prdata = '0;
        endcase
    end

endmodule

FILE: sv/slc_ctrl.sv
// controller of the cache lookup: request intake, row update and response hold
// depends on slc_pkg

module slc_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output slc_pkg::cmd_t  cmd
);

    slc_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;
    logic            commit;

    // handshakes and commands
    always_comb
    begin
        in_ready   = (state_reg == slc_pkg::ST_IDLE);
        accept     = in_valid && in_ready;
        // the row update waits until the response register can take the result
        commit     = (state_reg == slc_pkg::ST_LOOKUP) && (!out_valid_reg || out_ready);
        cmd.load   = accept;
        cmd.commit = commit;
        out_valid  = out_valid_reg;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            slc_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = slc_pkg::ST_LOOKUP;
                end
            end
            slc_pkg::ST_LOOKUP:
            begin
                if (commit)
                begin
                    state_next = slc_pkg::ST_IDLE;
                end
            end
            default: state_next = slc_pkg::ST_IDLE;
        endcase
    end

    // response valid flag
    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= slc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: sv/slc_dp.sv
// datapath of the cache lookup: address split, set row memory, valid flops,
// tag compare, lru update, counters and response register; depends on slc_pkg

module slc_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  slc_pkg::cmd_t                     cmd,
    input  slc_pkg::cfg_t                     cfg,
    input  logic [slc_pkg::ADDR_WIDTH-1:0]    addr,
    output logic                              hit,
    output logic [slc_pkg::OUT_WAY_W-1:0]     way,
    output logic [slc_pkg::OUT_SET_W-1:0]     set_index,
    output logic [slc_pkg::OUT_OFF_W-1:0]     block_offset,
    output logic                              evicted_valid,
    output logic [slc_pkg::CNT_W-1:0]         read_total,
    output logic [slc_pkg::CNT_W-1:0]         miss_total
);

    // set memory, one row per set
    slc_pkg::row_t mem [slc_pkg::SETS];
    slc_pkg::row_t rd_row_reg;

    // valid bits per way, cleared by reset
    logic [slc_pkg::WAYS-1:0] valid_reg [slc_pkg::SETS];

    // latched request
    logic [slc_pkg::SET_W-1:0]     set_reg;
    logic [slc_pkg::TAG_W-1:0]     tag_reg;
    logic [slc_pkg::OUT_OFF_W-1:0] offset_reg;
    logic [slc_pkg::CFG_W-1:0]     nw_reg;

    // counters and response payload
    logic [slc_pkg::CNT_W-1:0]     reads_reg, reads_next;
    logic [slc_pkg::CNT_W-1:0]     misses_reg, misses_next;
    logic                          hit_reg;
    logic [slc_pkg::OUT_WAY_W-1:0] way_reg;
    logic [slc_pkg::OUT_SET_W-1:0] set_out_reg;
    logic [slc_pkg::OUT_OFF_W-1:0] offset_out_reg;
    logic                          evict_reg;

    // request-side signals
    logic [slc_pkg::CFG_W-1:0]      ob;
    logic [slc_pkg::CFG_W-1:0]      sb;
    logic [slc_pkg::CFG_W-1:0]      nw;
    logic [slc_pkg::ADDR_WIDTH-1:0] set_mask;
    logic [slc_pkg::ADDR_WIDTH-1:0] off_mask;
    logic [slc_pkg::SET_W-1:0]      set_idx;
    logic [slc_pkg::TAG_W-1:0]      tag_in;
    logic [slc_pkg::OUT_OFF_W-1:0]  offset_in;

    // lookup-side signals
    logic [slc_pkg::WAYS-1:0]  cur_valid;
    slc_pkg::order_t           cur_order;
    slc_pkg::order_t           new_order;
    slc_pkg::tag_row_t         new_tags;
    logic                      found;
    logic [slc_pkg::WAY_W-1:0] hit_pos;
    logic [slc_pkg::WAY_W-1:0] sel_pos;
    logic [slc_pkg::WAY_W-1:0] way_sel;
    logic                      evict;

    // clamp field widths and split the address
    always_comb
    begin
        if (cfg.offset_bits < slc_pkg::OFFSET_MIN)
        begin
            ob = slc_pkg::OFFSET_MIN;
        end
        else if (cfg.offset_bits > slc_pkg::OFFSET_MAX)
        begin
            ob = slc_pkg::OFFSET_MAX;
        end
        else
        begin
            ob = cfg.offset_bits;
        end

        sb = (cfg.set_bits > slc_pkg::SETBITS_MAX) ? slc_pkg::SETBITS_MAX : cfg.set_bits;

        if (cfg.ways_in_use == '0)
        begin
            nw = slc_pkg::CFG_W'(1);
        end
        else if (32'(cfg.ways_in_use) > slc_pkg::WAYS)
        begin
            nw = slc_pkg::CFG_W'(slc_pkg::WAYS);
        end
        else
        begin
            nw = cfg.ways_in_use;
        end

        set_mask  = (slc_pkg::ADDR_WIDTH'(1) << sb) - slc_pkg::ADDR_WIDTH'(1);
        off_mask  = (slc_pkg::ADDR_WIDTH'(1) << ob) - slc_pkg::ADDR_WIDTH'(1);
        set_idx   = slc_pkg::SET_W'((addr >> ob) & set_mask
                                    & slc_pkg::ADDR_WIDTH'(slc_pkg::SETS - 1));
        tag_in    = slc_pkg::TAG_W'(addr >> (4'(ob) + 4'(sb)));
        offset_in = slc_pkg::OUT_OFF_W'(addr & off_mask);
    end

    // latch request fields
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            set_reg    <= set_idx;
            tag_reg    <= tag_in;
            offset_reg <= offset_in;
            nw_reg     <= nw;
        end
    end

    // row memory read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rd_row_reg <= mem[set_idx];
        end
    end

    // tag compare over the positions in use, first match wins
    always_comb
    begin
        cur_valid = valid_reg[set_reg];
        // a set never touched has no valid way, so its reset order is used in place of the row's
        cur_order = (|cur_valid) ? rd_row_reg.order : slc_pkg::reset_order();
        found     = 1'b0;
        hit_pos   = '0;
        for (int p = 0; p < slc_pkg::WAYS; p++)
        begin
            if (!found && (p < int'(nw_reg)) && cur_valid[cur_order[p]]
                && (rd_row_reg.tags[cur_order[p]] == tag_reg))
            begin
                found   = 1'b1;
                hit_pos = slc_pkg::WAY_W'(p);
            end
        end

        // on a miss the last position in use is the victim
        sel_pos = found ? hit_pos : slc_pkg::WAY_W'(nw_reg - 3'd1);
        way_sel = cur_order[sel_pos];
        evict   = !found && cur_valid[way_sel];

        // move the selected way to the front
        new_order[0] = way_sel;
        for (int i = 1; i < slc_pkg::WAYS; i++)
        begin
            new_order[i] = (i <= int'(sel_pos)) ? cur_order[i-1] : cur_order[i];
        end

        new_tags = rd_row_reg.tags;
        if (!found)
        begin
            new_tags[way_sel] = tag_reg;
        end

        reads_next  = reads_reg + slc_pkg::CNT_W'(1);
        misses_next = found ? misses_reg : misses_reg + slc_pkg::CNT_W'(1);
    end

    // row memory write
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            mem[set_reg] <= '{tags: new_tags, order: new_order};
        end
    end

    // valid bits and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < slc_pkg::SETS; s++)
            begin
                valid_reg[s] <= '0;
            end
            reads_reg  <= '0;
            misses_reg <= '0;
        end
        else if (cmd.commit)
        begin
            valid_reg[set_reg][way_sel] <= 1'b1;
            reads_reg                   <= reads_next;
            misses_reg                  <= misses_next;
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            hit_reg        <= found;
            way_reg        <= slc_pkg::OUT_WAY_W'(way_sel);
            set_out_reg    <= slc_pkg::OUT_SET_W'(set_reg);
            offset_out_reg <= offset_reg;
            evict_reg      <= evict;
        end
    end

    assign hit           = hit_reg;
    assign way           = way_reg;
    assign set_index     = set_out_reg;
    assign block_offset  = offset_out_reg;
    assign evicted_valid = evict_reg;
    assign read_total    = reads_reg;
    assign miss_total    = misses_reg;

endmodule
